FILE: rtl/hcbd_pkg.sv
package hcbd_pkg;

    localparam int DEF_SIZE_BITS     = 32;
    localparam int DEF_MAX_SIZE_LINE = 19;
    localparam int CAP_W             = 24;
    localparam logic [CAP_W-1:0] CAP_RESET = 24'd65536;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;
    localparam logic [7:0] CHAR_X_LOW = 8'h78;

    localparam logic [1:0] STATUS_BUSY = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_PAYLOAD,
        PH_AFTER,
        PH_OK,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        ST_BLANKS,
        ST_SIGNED,
        ST_ZERO,
        ST_PREFIX,
        ST_DIGITS,
        ST_STOPPED
    } t_stage;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       end_of_body;
    } t_in_beat;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

FILE: rtl/hcbd_in_reg.sv
module hcbd_in_reg import hcbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_beat i_beat,
    output logic     o_valid,
    output t_in_beat o_beat,
    input  logic     i_take
);

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: rtl/hcbd_char_parse.sv
module hcbd_char_parse import hcbd_pkg::*; #(
    parameter int SIZE_BITS     = DEF_SIZE_BITS,
    parameter int MAX_SIZE_LINE = DEF_MAX_SIZE_LINE,
    parameter int LEN_W         = $clog2(MAX_SIZE_LINE + 1)
) (
    input  logic [7:0]           i_char,
    input  logic [LEN_W-1:0]     i_len,
    input  logic [SIZE_BITS-1:0] i_acc,
    input  t_stage               i_stage,
    input  logic                 i_neg,
    output logic [LEN_W-1:0]     o_len,
    output logic [SIZE_BITS-1:0] o_acc,
    output t_stage               o_stage,
    output logic                 o_neg,
    output logic                 o_overflow
);

    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] acc_step;
    logic                 blank;
    logic                 sign;
    logic                 lead;

    always_comb begin
        hex = hex_digit(i_char);
        // Saturate once another digit would shift bits out of the top.
        if (i_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            acc_step = '1;
        end else begin
            acc_step = {i_acc[SIZE_BITS-5:0], hex[3:0]};
        end
        blank = (i_char == CHAR_SPACE) || (i_char inside {[CHAR_TAB:CHAR_CR]});
        sign  = (i_char == CHAR_PLUS) || (i_char == CHAR_MINUS);
        lead  = (i_stage == ST_BLANKS);

        o_overflow = (i_len >= LEN_W'(MAX_SIZE_LINE));
        o_len      = i_len + 1'b1;
        o_acc      = i_acc;
        o_stage    = i_stage;
        o_neg      = i_neg;

        case (i_stage)
            ST_BLANKS, ST_SIGNED: begin
                if (lead && blank) begin
                    o_stage = i_stage;
                end else if (lead && sign) begin
                    o_neg   = (i_char == CHAR_MINUS);
                    o_stage = ST_SIGNED;
                end else if (i_char == CHAR_ZERO) begin
                    o_stage = ST_ZERO;
                end else if (hex[4]) begin
                    o_acc   = acc_step;
                    o_stage = ST_DIGITS;
                end else begin
                    o_stage = ST_STOPPED;
                end
            end
            ST_ZERO: begin
                if (i_char == CHAR_X_LOW || i_char == CHAR_X_UP) begin
                    o_stage = ST_PREFIX;
                end else if (hex[4]) begin
                    o_acc   = acc_step;
                    o_stage = ST_DIGITS;
                end else begin
                    o_stage = ST_STOPPED;
                end
            end
            ST_PREFIX, ST_DIGITS: begin
                if (hex[4]) begin
                    o_acc   = acc_step;
                    o_stage = ST_DIGITS;
                end else begin
                    o_stage = ST_STOPPED;
                end
            end
            default: begin
                o_stage = i_stage;
            end
        endcase
    end

endmodule

FILE: rtl/hcbd_core.sv
module hcbd_core import hcbd_pkg::*; #(
    parameter int SIZE_BITS     = DEF_SIZE_BITS,
    parameter int MAX_SIZE_LINE = DEF_MAX_SIZE_LINE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat_valid,
    input  t_in_beat         i_beat,
    output logic             o_take,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_byte,
    output logic [1:0]       o_body_status,
    output logic [CAP_W-1:0] o_decoded_count
);

    localparam int LEN_W = $clog2(MAX_SIZE_LINE + 1);

    // Body state.
    t_phase               r_phase,  n_phase;
    logic [LEN_W-1:0]     r_len,    n_len;
    logic [SIZE_BITS-1:0] r_acc,    n_acc;
    t_stage               r_stage,  n_stage;
    logic                 r_neg,    n_neg;
    logic [SIZE_BITS-1:0] r_rem,    n_rem;
    logic [CAP_W-1:0]     r_cnt,    n_cnt;
    logic                 r_pcr,    n_pcr;
    logic [CAP_W-1:0]     r_cap;

    // Result register.
    logic             r_out_valid, n_out_valid;
    logic             r_pv,        n_pv;
    logic [7:0]       r_pb,        n_pb;
    logic [1:0]       r_status,    n_status;
    logic [CAP_W-1:0] r_count,     n_count;

    // Line state that the current byte works on.
    logic [LEN_W-1:0]     base_len;
    logic [SIZE_BITS-1:0] base_acc;
    t_stage               base_stage;
    logic                 base_neg;
    logic                 base_pcr;

    logic [LEN_W-1:0]     a_len,   b_len,   bi_len;
    logic [SIZE_BITS-1:0] a_acc,   b_acc,   bi_acc;
    t_stage               a_stage, b_stage, bi_stage;
    logic                 a_neg,   b_neg,   bi_neg;
    logic                 a_ovf,   b_ovf;
    logic                 a_en,    b_en;

    logic [7:0] byte_in;
    logic       last;
    logic       take;

    assign byte_in = i_beat.body_byte;
    assign last    = i_beat.end_of_body;
    assign take    = i_beat_valid && (!r_out_valid || !i_out_stall);
    assign o_take  = take;

    always_comb begin
        if (r_phase == PH_LINE) begin
            base_len   = r_len;
            base_acc   = r_acc;
            base_stage = r_stage;
            base_neg   = r_neg;
            base_pcr   = r_pcr;
        end else begin
            base_len   = '0;
            base_acc   = '0;
            base_stage = ST_BLANKS;
            base_neg   = 1'b0;
            base_pcr   = (r_phase == PH_AFTER) && r_pcr;
        end
        // A CR not followed by LF counts as a line character of its own.
        a_en = base_pcr && (byte_in != CHAR_LF);
        b_en = (byte_in != CHAR_CR) && !(a_en && a_ovf);
        if (a_en) begin
            bi_len   = a_len;
            bi_acc   = a_acc;
            bi_stage = a_stage;
            bi_neg   = a_neg;
        end else begin
            bi_len   = base_len;
            bi_acc   = base_acc;
            bi_stage = base_stage;
            bi_neg   = base_neg;
        end
    end

    hcbd_char_parse #(
        .SIZE_BITS     (SIZE_BITS),
        .MAX_SIZE_LINE (MAX_SIZE_LINE),
        .LEN_W         (LEN_W)
    ) u_parse_cr (
        .i_char     (CHAR_CR),
        .i_len      (base_len),
        .i_acc      (base_acc),
        .i_stage    (base_stage),
        .i_neg      (base_neg),
        .o_len      (a_len),
        .o_acc      (a_acc),
        .o_stage    (a_stage),
        .o_neg      (a_neg),
        .o_overflow (a_ovf)
    );

    hcbd_char_parse #(
        .SIZE_BITS     (SIZE_BITS),
        .MAX_SIZE_LINE (MAX_SIZE_LINE),
        .LEN_W         (LEN_W)
    ) u_parse_byte (
        .i_char     (byte_in),
        .i_len      (bi_len),
        .i_acc      (bi_acc),
        .i_stage    (bi_stage),
        .i_neg      (bi_neg),
        .o_len      (b_len),
        .o_acc      (b_acc),
        .o_stage    (b_stage),
        .o_neg      (b_neg),
        .o_overflow (b_ovf)
    );

    always_comb begin
        logic line_apply;
        line_apply = 1'b0;
        n_phase = r_phase;
        n_len   = r_len;
        n_acc   = r_acc;
        n_stage = r_stage;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_pcr   = r_pcr;
        n_pv    = 1'b0;
        n_pb    = 8'd0;

        case (r_phase)
            PH_LINE: begin
                if (r_pcr && byte_in == CHAR_LF) begin
                    n_pcr = 1'b0;
                    if (r_len == '0) begin
                        n_phase = PH_ERR;
                    end else if (r_acc == '0 || r_neg) begin
                        n_phase = PH_OK;
                    end else begin
                        n_rem   = r_acc;
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    line_apply = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (r_cnt < r_cap) begin
                    n_pv  = 1'b1;
                    n_pb  = byte_in;
                    n_cnt = r_cnt + 1'b1;
                end
                n_rem = r_rem - 1'b1;
                if (n_rem == '0) begin
                    n_phase = PH_AFTER;
                    n_pcr   = 1'b0;
                end
            end
            PH_AFTER: begin
                if (r_pcr && byte_in == CHAR_LF) begin
                    n_phase = PH_LINE;
                    n_len   = '0;
                    n_acc   = '0;
                    n_stage = ST_BLANKS;
                    n_neg   = 1'b0;
                    n_pcr   = 1'b0;
                end else if (!r_pcr && byte_in == CHAR_CR) begin
                    n_pcr = 1'b1;
                end else begin
                    line_apply = 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (line_apply) begin
            if ((a_en && a_ovf) || (b_en && b_ovf)) begin
                n_phase = PH_ERR;
            end else begin
                n_phase = PH_LINE;
                n_len   = b_en ? b_len   : bi_len;
                n_acc   = b_en ? b_acc   : bi_acc;
                n_stage = b_en ? b_stage : bi_stage;
                n_neg   = b_en ? b_neg   : bi_neg;
                n_pcr   = (byte_in == CHAR_CR);
            end
        end

        if (last && n_phase != PH_OK && n_phase != PH_ERR) begin
            case (n_phase)
                PH_LINE:    n_phase = (n_len == '0 && !n_pcr) ? PH_OK : PH_ERR;
                PH_PAYLOAD: n_phase = PH_ERR;
                default:    n_phase = n_pcr ? PH_ERR : PH_OK;
            endcase
        end

        case (n_phase)
            PH_OK:   n_status = STATUS_OK;
            PH_ERR:  n_status = STATUS_ERR;
            default: n_status = STATUS_BUSY;
        endcase
        n_count = n_cnt;

        // The beat that ends a body leaves everything ready for the next body.
        if (last) begin
            n_phase = PH_LINE;
            n_len   = '0;
            n_acc   = '0;
            n_stage = ST_BLANKS;
            n_neg   = 1'b0;
            n_rem   = '0;
            n_cnt   = '0;
            n_pcr   = 1'b0;
        end

        n_out_valid = take || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE;
            r_len       <= '0;
            r_acc       <= '0;
            r_stage     <= ST_BLANKS;
            r_neg       <= 1'b0;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_pcr       <= 1'b0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_acc   <= n_acc;
                r_stage <= n_stage;
                r_neg   <= n_neg;
                r_rem   <= n_rem;
                r_cnt   <= n_cnt;
                r_pcr   <= n_pcr;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
        if (take) begin
            r_pv     <= n_pv;
            r_pb     <= n_pb;
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_pv;
    assign o_payload_byte  = r_pb;
    assign o_body_status   = r_status;
    assign o_decoded_count = r_count;

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// Path: a beat is held in the input register, then its result in the result register.
// Throughput: one body byte per cycle while the output is not stalled; the input register and the result
// register let a new beat in while a finished result waits on a stalled output.
// Reset (i_rst_n low, synchronous) empties both registers, returns the framing
// state to the start of a size line and sets the output capacity to 65536.
module http_chunked_body_decoder import hcbd_pkg::*; #(
    parameter int SIZE_BITS     = DEF_SIZE_BITS,
    parameter int MAX_SIZE_LINE = DEF_MAX_SIZE_LINE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_body_byte,
    input  logic             i_end_of_body,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_byte,
    output logic [1:0]       o_body_status,
    output logic [CAP_W-1:0] o_decoded_count,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_in_beat in_beat;
    t_in_beat held_beat;
    logic     held_valid;
    logic     take;

    assign in_beat.body_byte   = i_body_byte;
    assign in_beat.end_of_body = i_end_of_body;

    hcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_beat  (in_beat),
        .o_valid (held_valid),
        .o_beat  (held_beat),
        .i_take  (take)
    );

    hcbd_core #(
        .SIZE_BITS     (SIZE_BITS),
        .MAX_SIZE_LINE (MAX_SIZE_LINE)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat_valid    (held_valid),
        .i_beat          (held_beat),
        .o_take          (take),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_body_status   (o_body_status),
        .o_decoded_count (o_decoded_count)
    );

endmodule

FILE: rtl/hcbd_checker.sv
module hcbd_checker import hcbd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_payload_valid,
    input logic [7:0]       o_payload_byte,
    input logic [1:0]       o_body_status,
    input logic [CAP_W-1:0] o_decoded_count
);

    // A beat without payload carries a zero byte.
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_payload_valid |-> o_payload_byte == 8'd0)
        else $error("payload byte not zero on a beat without payload");

    // A payload beat has always been counted, so the count cannot be zero.
    a_payload_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_valid |-> o_decoded_count != '0)
        else $error("payload beat with zero count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_body_status == STATUS_BUSY || o_body_status == STATUS_OK
            || o_body_status == STATUS_ERR)
        else $error("body status outside its codes");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_decoded_count) && $stable(o_body_status))
        else $error("stalled result beat changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_payload_valid (o_payload_valid),
    .o_payload_byte  (o_payload_byte),
    .o_body_status   (o_body_status),
    .o_decoded_count (o_decoded_count)
);
